@@ design/lpt_pkg.sv @@
package lpt_pkg;

   localparam int MAX_NODES = 1024;
   localparam int MAX_ARCS  = 4096;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES) + 1;
   localparam int ARC_AW    = $clog2(MAX_ARCS);
   localparam int ARC_CW    = $clog2(MAX_ARCS) + 1;
   localparam int DEG_W     = $clog2(MAX_ARCS) + 1;

   localparam logic [NODE_W-1:0] LEVEL_MAX = {NODE_W{1'b1}};

   // item action codes
   localparam logic [1:0] ACT_ADD_ARC = 2'd0;
   localparam logic [1:0] ACT_RUN     = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;
   localparam logic [1:0] ACT_CLEAR   = 2'd3;

   // one access to the per-node memories, all at one address
   typedef struct packed {
      logic [NODE_W-1:0] addr;
      logic              level_we;
      logic [NODE_W-1:0] level;
      logic              deg_we;
      logic [DEG_W-1:0]  deg;
      logic              popped_we;
      logic              popped;
   } node_req_type;

   typedef struct packed {
      logic [NODE_W-1:0] level;
      logic [DEG_W-1:0]  deg;
      logic              popped;
   } node_rsp_type;

endpackage

@@ design/lpt_arc_mem.sv @@
module lpt_arc_mem
   import lpt_pkg::*;
(
   input  logic              clock,
   input  logic [ARC_AW-1:0] addr,
   input  logic              we,
   input  logic [NODE_W-1:0] wr_source,
   input  logic [NODE_W-1:0] wr_target,
   output logic [NODE_W-1:0] rd_source,
   output logic [NODE_W-1:0] rd_target
);

   logic [NODE_W-1:0] source_mem [MAX_ARCS];
   logic [NODE_W-1:0] target_mem [MAX_ARCS];

   // arc list, one port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         source_mem[addr] <= wr_source;
         target_mem[addr] <= wr_target;
      end
      rd_source <= source_mem[addr];
      rd_target <= target_mem[addr];
   end

endmodule

@@ design/lpt_node_mem.sv @@
module lpt_node_mem
   import lpt_pkg::*;
(
   input  logic         clock,
   input  node_req_type req,
   output node_rsp_type rsp
);

   logic [NODE_W-1:0] level_mem  [MAX_NODES];
   logic [DEG_W-1:0]  deg_mem    [MAX_NODES];
   logic              popped_mem [MAX_NODES];

   // level, pending in-degree and popped flag share one address
   always_ff @(posedge clock) begin
      if (req.level_we) begin
         level_mem[req.addr] <= req.level;
      end
      if (req.deg_we) begin
         deg_mem[req.addr] <= req.deg;
      end
      if (req.popped_we) begin
         popped_mem[req.addr] <= req.popped;
      end
      rsp.level  <= level_mem[req.addr];
      rsp.deg    <= deg_mem[req.addr];
      rsp.popped <= popped_mem[req.addr];
   end

endmodule

@@ design/lpt_stack_mem.sv @@
module lpt_stack_mem
   import lpt_pkg::*;
(
   input  logic              clock,
   input  logic [NODE_W-1:0] addr,
   input  logic              we,
   input  logic [NODE_W-1:0] wdata,
   output logic [NODE_W-1:0] rdata
);

   logic [NODE_W-1:0] stack_mem [MAX_NODES];

   // ready stack, one port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         stack_mem[addr] <= wdata;
      end
      rdata <= stack_mem[addr];
   end

endmodule

@@ design/longest_path_topological_levels.sv @@
// Longest-path layering by a Kahn topological walk. An item is taken when
// start is high and busy is low; every item gives exactly one result, shown
// for one cycle with rsp_valid, and the receiver cannot hold it off. Add-arc
// and clear-arcs leave busy low, so they can follow back to back; a level
// read raises busy. In a run each popped node scans the whole arc list
// through the single arc memory port, and every matching arc costs a
// read-modify-write of its target. After reset a clearing pass over all
// node addresses zeroes levels and popped flags while busy is high;
// register writes are taken during it.
module longest_path_topological_levels
   import lpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic [NODE_W-1:0] req_arc_source,
   input  logic [NODE_W-1:0] req_arc_target,
   input  logic [NODE_W-1:0] req_query_node,
   output logic              rsp_valid,
   output logic [NODE_W-1:0] rsp_level,
   output logic              rsp_reached,
   output logic [CNT_W-1:0]  rsp_unreached_count,
   output logic              rsp_arc_overflow,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_QOUT  = 4'd2;
   localparam logic [3:0] S_CLR   = 4'd3;
   localparam logic [3:0] S_CNT_A = 4'd4;
   localparam logic [3:0] S_CNT_B = 4'd5;
   localparam logic [3:0] S_CNT_C = 4'd6;
   localparam logic [3:0] S_PSH_A = 4'd7;
   localparam logic [3:0] S_PSH_B = 4'd8;
   localparam logic [3:0] S_POP_A = 4'd9;
   localparam logic [3:0] S_POP_B = 4'd10;
   localparam logic [3:0] S_POP_C = 4'd11;
   localparam logic [3:0] S_SCN_A = 4'd12;
   localparam logic [3:0] S_SCN_B = 4'd13;
   localparam logic [3:0] S_SCN_C = 4'd14;

   localparam logic [CNT_W-1:0] NODES_FULL = CNT_W'(MAX_NODES);
   localparam logic [ARC_CW-1:0] ARCS_FULL = ARC_CW'(MAX_ARCS);

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  node_count_ff, node_count_in;
   logic [ARC_CW-1:0] arc_total_ff, arc_total_in;
   logic [ARC_CW-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  top_ff, top_in;
   logic [CNT_W-1:0]  popped_cnt_ff, popped_cnt_in;
   logic [NODE_W-1:0] v_ff, v_in;
   logic [NODE_W-1:0] t_ff, t_in;
   logic [NODE_W-1:0] next_ff, next_in;
   logic              q_ok_ff, q_ok_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_level_ff, rsp_level_in;
   logic              rsp_reached_ff, rsp_reached_in;
   logic [CNT_W-1:0]  rsp_unreached_ff, rsp_unreached_in;
   logic              rsp_overflow_ff, rsp_overflow_in;

   logic [CNT_W-1:0]  n_use;
   logic              accept;
   logic              csr_wr;

   logic [ARC_AW-1:0] arc_addr;
   logic              arc_we;
   logic [NODE_W-1:0] arc_rd_source, arc_rd_target;
   node_req_type      node_req;
   node_rsp_type      node_rsp;
   logic [NODE_W-1:0] stk_addr;
   logic              stk_we;
   logic [NODE_W-1:0] stk_wdata, stk_rdata;

   lpt_arc_mem u_arc_mem (
      .clock     (clock),
      .addr      (arc_addr),
      .we        (arc_we),
      .wr_source (req_arc_source),
      .wr_target (req_arc_target),
      .rd_source (arc_rd_source),
      .rd_target (arc_rd_target)
   );

   lpt_node_mem u_node_mem (
      .clock (clock),
      .req   (node_req),
      .rsp   (node_rsp)
   );

   lpt_stack_mem u_stack_mem (
      .clock (clock),
      .addr  (stk_addr),
      .we    (stk_we),
      .wdata (stk_wdata),
      .rdata (stk_rdata)
   );

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && !paddr[2];
   assign prdata = paddr[2] ? 32'd0 : 32'(node_count_ff);
   assign node_count_in = csr_wr ? pwdata[CNT_W-1:0] : node_count_ff;

   // nodes in use, clamped to 1..MAX_NODES
   always_comb begin
      if (node_count_ff == '0) begin
         n_use = CNT_W'(1);
      end else if (node_count_ff > NODES_FULL) begin
         n_use = NODES_FULL;
      end else begin
         n_use = node_count_ff;
      end
   end

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // sequencer
   always_comb begin
      state_in         = state_ff;
      arc_total_in     = arc_total_ff;
      idx_in           = idx_ff;
      top_in           = top_ff;
      popped_cnt_in    = popped_cnt_ff;
      v_in             = v_ff;
      t_in             = t_ff;
      next_in          = next_ff;
      q_ok_in          = q_ok_ff;
      rsp_valid_in     = 1'b0;
      rsp_level_in     = '0;
      rsp_reached_in   = 1'b0;
      rsp_unreached_in = '0;
      rsp_overflow_in  = 1'b0;
      arc_addr         = idx_ff[ARC_AW-1:0];
      arc_we           = 1'b0;
      node_req         = '0;
      node_req.addr    = idx_ff[NODE_W-1:0];
      stk_addr         = top_ff[NODE_W-1:0];
      stk_we           = 1'b0;
      stk_wdata        = idx_ff[NODE_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            node_req.level_we  = 1'b1;
            node_req.popped_we = 1'b1;
            idx_in = idx_ff + ARC_CW'(1);
            if (idx_ff[NODE_W-1:0] == LEVEL_MAX) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            node_req.addr = req_query_node;
            arc_addr      = arc_total_ff[ARC_AW-1:0];
            if (accept) begin
               case (req_action)
                  ACT_ADD_ARC: begin
                     rsp_valid_in = 1'b1;
                     if (arc_total_ff < ARCS_FULL) begin
                        arc_we       = 1'b1;
                        arc_total_in = arc_total_ff + ARC_CW'(1);
                     end else begin
                        rsp_overflow_in = 1'b1;
                     end
                  end
                  ACT_RUN: begin
                     idx_in        = '0;
                     top_in        = '0;
                     popped_cnt_in = '0;
                     state_in      = S_CLR;
                  end
                  ACT_READ: begin
                     q_ok_in  = ({1'b0, req_query_node} < n_use);
                     state_in = S_QOUT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     arc_total_in = '0;
                  end
               endcase
            end
         end
         S_QOUT: begin
            rsp_valid_in   = 1'b1;
            rsp_level_in   = q_ok_ff ? node_rsp.level : '0;
            rsp_reached_in = q_ok_ff && node_rsp.popped;
            state_in       = S_IDLE;
         end
         // zero all levels, flags and in-degrees
         S_CLR: begin
            node_req.level_we  = 1'b1;
            node_req.deg_we    = 1'b1;
            node_req.popped_we = 1'b1;
            idx_in = idx_ff + ARC_CW'(1);
            if (idx_ff[NODE_W-1:0] == LEVEL_MAX) begin
               idx_in   = '0;
               state_in = S_CNT_A;
            end
         end
         // count in-degrees over arcs with both ends in use
         S_CNT_A: begin
            if (idx_ff == arc_total_ff) begin
               idx_in   = '0;
               state_in = S_PSH_A;
            end else begin
               state_in = S_CNT_B;
            end
         end
         S_CNT_B: begin
            node_req.addr = arc_rd_target;
            t_in          = arc_rd_target;
            if (({1'b0, arc_rd_source} < n_use) && ({1'b0, arc_rd_target} < n_use)) begin
               state_in = S_CNT_C;
            end else begin
               idx_in   = idx_ff + ARC_CW'(1);
               state_in = S_CNT_A;
            end
         end
         S_CNT_C: begin
            node_req.addr   = t_ff;
            node_req.deg_we = 1'b1;
            node_req.deg    = node_rsp.deg + DEG_W'(1);
            idx_in          = idx_ff + ARC_CW'(1);
            state_in        = S_CNT_A;
         end
         // push every in-degree-zero node
         S_PSH_A: begin
            if (idx_ff == ARC_CW'(n_use)) begin
               state_in = S_POP_A;
            end else begin
               state_in = S_PSH_B;
            end
         end
         S_PSH_B: begin
            if (node_rsp.deg == '0) begin
               stk_we = 1'b1;
               top_in = top_ff + CNT_W'(1);
            end
            idx_in   = idx_ff + ARC_CW'(1);
            state_in = S_PSH_A;
         end
         // pop the next ready node or finish
         S_POP_A: begin
            if (top_ff == '0) begin
               rsp_valid_in     = 1'b1;
               rsp_unreached_in = n_use - popped_cnt_ff;
               state_in         = S_IDLE;
            end else begin
               stk_addr = NODE_W'(top_ff - CNT_W'(1));
               top_in   = top_ff - CNT_W'(1);
               state_in = S_POP_B;
            end
         end
         S_POP_B: begin
            node_req.addr      = stk_rdata;
            node_req.popped_we = 1'b1;
            node_req.popped    = 1'b1;
            v_in               = stk_rdata;
            popped_cnt_in      = popped_cnt_ff + CNT_W'(1);
            state_in           = S_POP_C;
         end
         S_POP_C: begin
            next_in  = (node_rsp.level == LEVEL_MAX) ? LEVEL_MAX
                                                     : node_rsp.level + NODE_W'(1);
            idx_in   = '0;
            state_in = S_SCN_A;
         end
         // scan arcs for successors of the popped node
         S_SCN_A: begin
            if (idx_ff == arc_total_ff) begin
               state_in = S_POP_A;
            end else begin
               state_in = S_SCN_B;
            end
         end
         S_SCN_B: begin
            node_req.addr = arc_rd_target;
            t_in          = arc_rd_target;
            if ((arc_rd_source == v_ff) && ({1'b0, arc_rd_target} < n_use)) begin
               state_in = S_SCN_C;
            end else begin
               idx_in   = idx_ff + ARC_CW'(1);
               state_in = S_SCN_A;
            end
         end
         S_SCN_C: begin
            node_req.addr     = t_ff;
            node_req.level_we = 1'b1;
            node_req.level    = (node_rsp.level < next_ff) ? next_ff : node_rsp.level;
            if (node_rsp.deg != '0) begin
               node_req.deg_we = 1'b1;
               node_req.deg    = node_rsp.deg - DEG_W'(1);
               if (node_rsp.deg == DEG_W'(1)) begin
                  stk_we    = 1'b1;
                  stk_wdata = t_ff;
                  top_in    = top_ff + CNT_W'(1);
               end
            end
            idx_in   = idx_ff + ARC_CW'(1);
            state_in = S_SCN_A;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         node_count_ff <= NODES_FULL;
         arc_total_ff  <= '0;
         idx_ff        <= '0;
         top_ff        <= '0;
         popped_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         arc_total_ff  <= arc_total_in;
         idx_ff        <= idx_in;
         top_ff        <= top_in;
         popped_cnt_ff <= popped_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      v_ff             <= v_in;
      t_ff             <= t_in;
      next_ff          <= next_in;
      q_ok_ff          <= q_ok_in;
      rsp_level_ff     <= rsp_level_in;
      rsp_reached_ff   <= rsp_reached_in;
      rsp_unreached_ff <= rsp_unreached_in;
      rsp_overflow_ff  <= rsp_overflow_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_level           = rsp_level_ff;
   assign rsp_reached         = rsp_reached_ff;
   assign rsp_unreached_count = rsp_unreached_ff;
   assign rsp_arc_overflow    = rsp_overflow_ff;

   // checks
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= NODES_FULL)
      else $error("ready stack pointer beyond node capacity");

   a_arc_bound: assert property (@(posedge clock) disable iff (reset)
      arc_total_ff <= ARCS_FULL)
      else $error("arc count beyond arc capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_overflow_ff |-> $past(arc_total_ff) == ARCS_FULL)
      else $error("overflow reported with room in arc store");

   a_level_from_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_level_ff != '0 || rsp_reached_ff) |-> $past(state_ff) == S_QOUT)
      else $error("level result outside a read");

endmodule
